### rtl/dtsd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dtsd_pkg
// Shared types, register codes, widths and the sine table generator for the
// dual-tone sliding-window detector.
// ---------------------------------------------------------------------------
package dtsd_pkg;

    // Default parameter values
    localparam int DEF_MAX_WINDOW      = 2048;
    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_SINE_INDEX_BITS = 12;

    // Fixed field widths
    localparam int PHASE_W    = 32;
    localparam int WIN_W      = 12;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TRIG_W     = 16;
    localparam int TRIG_MAG_W = 15;
    localparam int MIX_SHIFT  = 15;

    localparam logic [PHASE_W-1:0] QUARTER_PHASE = 32'h4000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FSK_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 3'd4;

    // Register reset values
    localparam logic                  RST_FSK_MODE        = 1'b1;
    localparam logic [PHASE_W-1:0]    RST_CARRIER_STEP    = 32'd536870912;
    localparam logic [PHASE_W-1:0]    RST_SHIFT_STEP      = 32'd17895697;
    localparam logic [WIN_W-1:0]      RST_WINDOW_LENGTH   = 12'd240;
    localparam logic [INTERVAL_W-1:0] RST_REPORT_INTERVAL = 16'd80;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_MUL,
        ST_ACC,
        ST_WRITE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SQ_ADD,
        ST_ROOT,
        ST_DONE
    } state_t;

    // First-quadrant sine magnitude in Q1.15 for quarter index r
    function automatic logic [TRIG_MAG_W-1:0] sine_mag(input int unsigned r,
                                                       input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = 64'(r) << (30 - qbits);
        x2 = (x * x) >> 30;
        t  = 64'd172272;
        t  = 64'd5026996 - ((t * x2) >> 30);
        t  = 64'd85569306 - ((t * x2) >> 30);
        t  = 64'd693598668 - ((t * x2) >> 30);
        t  = 64'd1686629713 - ((t * x2) >> 30);
        s  = (t * x) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[TRIG_MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/dual_tone_sliding_detector_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dual_tone_sliding_detector_core
// Sliding-window quadrature tone detector for FSK and OOK, one shared
// multiplier and a bit-serial square root under a small sequencer.
// ---------------------------------------------------------------------------
// Each mixer component (2 in OOK, 4 in FSK) passes ST_ADDR, ST_MUL and ST_ACC,
//   and ST_WRITE then stores the line entries and advances phases and count.
// A report runs ST_SQ_RE, ST_SQ_IM, ST_SQ_ADD and ST_ROOT per tone through
//   the shared multiplier and the one-bit-per-cycle root over RES_W (SUM_W,
//   28 by default) bits; ST_DONE loads the output once its register is free.
// in_ready is high only in ST_IDLE, so in_ready is low while a sample works.
// Reset: after rst_n releases, a clearing pass writes MAX_WINDOW (2048 by
//   default) line entries, one per cycle, before the first sample is accepted.

module dual_tone_sliding_detector_core #(
    parameter int MAX_WINDOW      = dtsd_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS     = dtsd_pkg::DEF_SAMPLE_BITS,
    parameter int SINE_INDEX_BITS = dtsd_pkg::DEF_SINE_INDEX_BITS
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         cfg_valid,
    output logic                                        cfg_ready,
    input  wire  [dtsd_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire  [dtsd_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  wire                                         in_valid,
    output logic                                        in_ready,
    input  wire  signed [SAMPLE_BITS-1:0]               sample,
    output logic                                        out_valid,
    input  wire                                         out_ready,
    output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]   mag_upper,
    output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]   mag_lower
);

    localparam int LOG_W   = $clog2(MAX_WINDOW);
    localparam int SUM_W   = SAMPLE_BITS + LOG_W + 1;
    localparam int MAG_W   = SUM_W - 1;
    localparam int MUL_W   = (SUM_W > dtsd_pkg::TRIG_W) ? SUM_W : dtsd_pkg::TRIG_W;
    localparam int SQ_W    = 2 * SUM_W;
    localparam int RES_W   = SUM_W;
    localparam int ITER_W  = $clog2(RES_W);
    localparam int QBITS   = SINE_INDEX_BITS - 2;
    localparam int ROM_DEPTH = (1 << QBITS) + 1;
    localparam int ROM_AW  = QBITS + 1;
    localparam int WC_W    = (dtsd_pkg::WIN_W > LOG_W + 1) ? dtsd_pkg::WIN_W : LOG_W + 1;
    localparam int IV_W    = dtsd_pkg::INTERVAL_W;
    localparam int PW      = dtsd_pkg::PHASE_W;
    localparam int LINE_W  = 2 * SAMPLE_BITS;

    typedef logic [dtsd_pkg::TRIG_MAG_W-1:0] rom_t [ROM_DEPTH];

    // Build the quarter-wave table, including the quarter-cycle endpoint
    function automatic rom_t build_rom();
        rom_t tab;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            tab[i] = dtsd_pkg::sine_mag(32'(i), 32'(QBITS));
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Configuration registers
    logic                  fsk_mode_reg;
    logic [PW-1:0]         carrier_step_reg;
    logic [PW-1:0]         shift_step_reg;
    logic [dtsd_pkg::WIN_W-1:0] window_length_reg;
    logic [IV_W-1:0]       report_interval_reg;

    // Control state
    dtsd_pkg::state_t      state_reg, state_next;
    logic [1:0]            comp_reg, comp_next;
    logic                  tone_reg, tone_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [LOG_W-1:0]      clr_reg, clr_next;
    logic [LOG_W-1:0]      pos_reg, pos_next;
    logic [IV_W-1:0]       count_reg, count_next;
    logic [PW-1:0]         carrier_reg, carrier_next;
    logic [PW-1:0]         shift_reg, shift_next;
    logic                  out_valid_reg, out_valid_next;

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0]  sample_reg;
    logic [dtsd_pkg::TRIG_MAG_W-1:0] rom_data_reg;
    logic                           neg_reg;
    logic signed [2*MUL_W-1:0]      prod_reg;
    logic signed [SAMPLE_BITS-1:0]  new_reg [4];
    logic signed [SUM_W-1:0]        sum_reg [4];
    logic [SQ_W-1:0]                acc_reg;
    logic [SQ_W-1:0]                rad_reg;
    logic [RES_W+1:0]               rem_reg;
    logic [RES_W-1:0]               root_reg;
    logic [MAG_W-1:0]               mag_up_reg;
    logic [MAG_W-1:0]               mag_upper_reg;
    logic [MAG_W-1:0]               mag_lower_reg;

    // Delay lines: upper and lower tone, {re, im} per entry
    logic [LINE_W-1:0]  up_mem [MAX_WINDOW];
    logic [LINE_W-1:0]  lo_mem [MAX_WINDOW];
    logic [LINE_W-1:0]  up_rd_reg;
    logic [LINE_W-1:0]  lo_rd_reg;

    // Combinational helpers
    logic [PW-1:0]                  tone_phase;
    logic [PW-1:0]                  phase;
    logic [SINE_INDEX_BITS-1:0]     sidx;
    logic [ROM_AW-1:0]              rom_addr;
    logic signed [dtsd_pkg::TRIG_W-1:0] trig_mag;
    logic signed [dtsd_pkg::TRIG_W-1:0] trig;
    logic [1:0]                     sum_sel;
    logic signed [SUM_W-1:0]        sum_val;
    logic signed [MUL_W-1:0]        mul_a;
    logic signed [MUL_W-1:0]        mul_b;
    logic signed [SAMPLE_BITS-1:0]  mix;
    logic signed [SAMPLE_BITS-1:0]  old_val;
    logic [1:0]                     last_comp;
    logic [WC_W-1:0]                win_ext;
    logic [WC_W-1:0]                win_eff;
    logic [WC_W-1:0]                pos_inc;
    logic [IV_W:0]                  count_inc;
    logic [IV_W-1:0]                ivl_eff;
    logic [RES_W+3:0]               rem_cat;
    logic [RES_W+3:0]               trial;
    logic                           root_ge;
    logic                           mem_we;
    logic                           lo_we;
    logic [LOG_W-1:0]               mem_addr;
    logic [LINE_W-1:0]              up_wdata;
    logic [LINE_W-1:0]              lo_wdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == dtsd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign mag_upper = mag_upper_reg;
    assign mag_lower = mag_lower_reg;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsk_mode_reg        <= dtsd_pkg::RST_FSK_MODE;
            carrier_step_reg    <= dtsd_pkg::RST_CARRIER_STEP;
            shift_step_reg      <= dtsd_pkg::RST_SHIFT_STEP;
            window_length_reg   <= dtsd_pkg::RST_WINDOW_LENGTH;
            report_interval_reg <= dtsd_pkg::RST_REPORT_INTERVAL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dtsd_pkg::REG_FSK_MODE:        fsk_mode_reg        <= cfg_data[0];
                dtsd_pkg::REG_CARRIER_STEP:    carrier_step_reg    <= cfg_data;
                dtsd_pkg::REG_SHIFT_STEP:      shift_step_reg      <= cfg_data;
                dtsd_pkg::REG_WINDOW_LENGTH:
                    window_length_reg <= cfg_data[dtsd_pkg::WIN_W-1:0];
                dtsd_pkg::REG_REPORT_INTERVAL: report_interval_reg <= cfg_data[IV_W-1:0];
                default: ;
            endcase
        end
    end

    // Form the sine table address for the current component
    always_comb
    begin
        if (comp_reg[1])
        begin
            tone_phase = carrier_reg - shift_reg;
        end
        else if (fsk_mode_reg)
        begin
            tone_phase = carrier_reg + shift_reg;
        end
        else
        begin
            tone_phase = carrier_reg;
        end
        phase = comp_reg[0] ? tone_phase : tone_phase + dtsd_pkg::QUARTER_PHASE;
        sidx  = phase[PW-1 -: SINE_INDEX_BITS];
        if (sidx[QBITS])
        begin
            rom_addr = ROM_AW'(ROM_DEPTH - 1) - {1'b0, sidx[QBITS-1:0]};
        end
        else
        begin
            rom_addr = {1'b0, sidx[QBITS-1:0]};
        end
    end

    // Select multiplier operands and the old line entry
    always_comb
    begin
        trig_mag = {1'b0, rom_data_reg};
        trig     = neg_reg ? -trig_mag : trig_mag;
        if (state_reg == dtsd_pkg::ST_SQ_RE)
        begin
            sum_sel = {tone_reg, 1'b0};
        end
        else if (state_reg == dtsd_pkg::ST_SQ_IM)
        begin
            sum_sel = {tone_reg, 1'b1};
        end
        else
        begin
            sum_sel = comp_reg;
        end
        sum_val = sum_reg[sum_sel];
        if (state_reg == dtsd_pkg::ST_MUL)
        begin
            mul_a = MUL_W'(sample_reg);
            mul_b = MUL_W'(trig);
        end
        else
        begin
            mul_a = MUL_W'(sum_val);
            mul_b = MUL_W'(sum_val);
        end
        mix = prod_reg[dtsd_pkg::MIX_SHIFT +: SAMPLE_BITS];
        case (comp_reg)
            2'd0:    old_val = up_rd_reg[LINE_W-1 -: SAMPLE_BITS];
            2'd1:    old_val = up_rd_reg[SAMPLE_BITS-1:0];
            2'd2:    old_val = lo_rd_reg[LINE_W-1 -: SAMPLE_BITS];
            default: old_val = lo_rd_reg[SAMPLE_BITS-1:0];
        endcase
        last_comp = fsk_mode_reg ? 2'd3 : 2'd1;
    end

    // Effective window, position wrap and report decision
    always_comb
    begin
        win_ext = WC_W'(window_length_reg);
        if (window_length_reg == '0)
        begin
            win_eff = WC_W'(1);
        end
        else if (win_ext > WC_W'(MAX_WINDOW))
        begin
            win_eff = WC_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = win_ext;
        end
        pos_inc   = WC_W'(pos_reg) + WC_W'(1);
        ivl_eff   = (report_interval_reg == '0) ? IV_W'(1) : report_interval_reg;
        count_inc = {1'b0, count_reg} + (IV_W+1)'(1);
    end

    // One root bit per cycle
    always_comb
    begin
        rem_cat = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = (rem_cat >= trial);
    end

    // Sequencer: next state and control
    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        tone_next      = tone_reg;
        iter_next      = iter_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        carrier_next   = carrier_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        lo_we          = 1'b0;
        mem_addr       = pos_reg;
        up_wdata       = {new_reg[0], new_reg[1]};
        lo_wdata       = {new_reg[2], new_reg[3]};
        case (state_reg)
            dtsd_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                lo_we    = 1'b1;
                mem_addr = clr_reg;
                up_wdata = '0;
                lo_wdata = '0;
                clr_next = clr_reg + LOG_W'(1);
                if (clr_reg == LOG_W'(MAX_WINDOW - 1))
                begin
                    state_next = dtsd_pkg::ST_IDLE;
                end
            end
            dtsd_pkg::ST_IDLE:
            begin
                comp_next = 2'd0;
                if (in_valid)
                begin
                    state_next = dtsd_pkg::ST_ADDR;
                end
            end
            dtsd_pkg::ST_ADDR:
            begin
                state_next = dtsd_pkg::ST_MUL;
            end
            dtsd_pkg::ST_MUL:
            begin
                state_next = dtsd_pkg::ST_ACC;
            end
            dtsd_pkg::ST_ACC:
            begin
                if (comp_reg == last_comp)
                begin
                    state_next = dtsd_pkg::ST_WRITE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = dtsd_pkg::ST_ADDR;
                end
            end
            dtsd_pkg::ST_WRITE:
            begin
                // Store new entries and advance position, phases, report count
                mem_we       = 1'b1;
                lo_we        = fsk_mode_reg;
                pos_next     = (pos_inc >= win_eff) ? '0 : pos_inc[LOG_W-1:0];
                carrier_next = carrier_reg + carrier_step_reg;
                if (fsk_mode_reg)
                begin
                    shift_next = shift_reg + shift_step_reg;
                end
                if (count_inc >= {1'b0, ivl_eff})
                begin
                    count_next = '0;
                    tone_next  = 1'b0;
                    state_next = dtsd_pkg::ST_SQ_RE;
                end
                else
                begin
                    count_next = count_inc[IV_W-1:0];
                    state_next = dtsd_pkg::ST_IDLE;
                end
            end
            dtsd_pkg::ST_SQ_RE:
            begin
                state_next = dtsd_pkg::ST_SQ_IM;
            end
            dtsd_pkg::ST_SQ_IM:
            begin
                state_next = dtsd_pkg::ST_SQ_ADD;
            end
            dtsd_pkg::ST_SQ_ADD:
            begin
                iter_next  = '0;
                state_next = dtsd_pkg::ST_ROOT;
            end
            dtsd_pkg::ST_ROOT:
            begin
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(RES_W - 1))
                begin
                    if (!tone_reg && fsk_mode_reg)
                    begin
                        tone_next  = 1'b1;
                        state_next = dtsd_pkg::ST_SQ_RE;
                    end
                    else
                    begin
                        state_next = dtsd_pkg::ST_DONE;
                    end
                end
            end
            dtsd_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = dtsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtsd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtsd_pkg::ST_CLEAR;
            comp_reg      <= '0;
            tone_reg      <= 1'b0;
            iter_reg      <= '0;
            clr_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            carrier_reg   <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            tone_reg      <= tone_next;
            iter_reg      <= iter_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            carrier_reg   <= carrier_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Moving sums, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (state_reg == dtsd_pkg::ST_ACC)
        begin
            sum_reg[comp_reg] <= sum_val + SUM_W'(mix) - SUM_W'(old_val);
        end
    end

    // Datapath: sample capture, table read, shared multiplier, root
    always_ff @(posedge clk)
    begin
        rom_data_reg <= SINE_ROM[rom_addr];
        if (state_reg == dtsd_pkg::ST_IDLE)
        begin
            sample_reg <= sample;
        end
        if (state_reg == dtsd_pkg::ST_ADDR)
        begin
            neg_reg <= sidx[SINE_INDEX_BITS-1];
        end
        if (state_reg == dtsd_pkg::ST_MUL || state_reg == dtsd_pkg::ST_SQ_RE ||
            state_reg == dtsd_pkg::ST_SQ_IM)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == dtsd_pkg::ST_ACC)
        begin
            new_reg[comp_reg] <= mix;
        end
        if (state_reg == dtsd_pkg::ST_SQ_IM)
        begin
            acc_reg <= prod_reg[SQ_W-1:0];
        end
        if (state_reg == dtsd_pkg::ST_SQ_ADD)
        begin
            rad_reg  <= acc_reg + prod_reg[SQ_W-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == dtsd_pkg::ST_ROOT)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= root_ge ? (RES_W+2)'(rem_cat - trial) : rem_cat[RES_W+1:0];
            root_reg <= {root_reg[RES_W-2:0], root_ge};
            if (iter_reg == ITER_W'(RES_W - 1) && !tone_reg)
            begin
                mag_up_reg <= {root_reg[MAG_W-2:0], root_ge};
            end
        end
        if (state_reg == dtsd_pkg::ST_DONE && (!out_valid_reg || out_ready))
        begin
            if (fsk_mode_reg)
            begin
                mag_upper_reg <= mag_up_reg;
                mag_lower_reg <= root_reg[MAG_W-1:0];
            end
            else
            begin
                mag_upper_reg <= root_reg[MAG_W-1:0];
                mag_lower_reg <= '0;
            end
        end
    end

    // Delay line memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            up_mem[mem_addr] <= up_wdata;
        end
        if (lo_we)
        begin
            lo_mem[mem_addr] <= lo_wdata;
        end
        up_rd_reg <= up_mem[pos_reg];
        lo_rd_reg <= lo_mem[pos_reg];
    end

endmodule
`default_nettype wire
